[hdl/pfe_pkg.sv]
// ---------------------------------------------------------------------------
// pfe_pkg
// Shared constants, codes and controller/datapath interface types for the
// postfix expression evaluator.
// ---------------------------------------------------------------------------
package pfe_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int CHAR_W      = 8;
  localparam int STATUS_W    = 3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FEW   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEPTH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIV0  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd4;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam int               RADIX      = 10;

  // stack read address select
  localparam logic [1:0] RD_TOP  = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_BASE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load_in;    // capture accepted input item
    logic       acc_step;   // fold digit into accumulator
    logic       push_num;   // push pending number and clear accumulator
    logic       push_res;   // push arithmetic result
    logic [1:0] rd_sel;     // stack read address
    logic       latch_x;    // capture top operand
    logic       latch_y;    // capture second operand and pop two
    logic       exec;       // compute add, subtract or multiply result
    logic       div_start;  // launch divider
    logic       div_latch;  // capture quotient
    logic       flag_few;   // too few operands
    logic       flag_div0;  // divide by zero
    logic       load_out;   // form result into output register
    logic       clear;      // return expression state to reset values
  } pfe_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_digit;
    logic is_space;
    logic is_arith;   // plus, minus or star
    logic is_div;
    logic last;
    logic pending;
    logic depth_lt2;
    logic x_zero;
    logic div_done;
    logic out_busy;   // output register full and not being taken
  } pfe_stat_t;

endpackage

[hdl/pfe_ram.sv]
// ---------------------------------------------------------------------------
// pfe_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/pfe_divider.sv]
// ---------------------------------------------------------------------------
// pfe_divider
// Iterative restoring divider, one quotient bit per cycle, signed quotient
// truncated toward zero.
// ---------------------------------------------------------------------------
module pfe_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [pfe_pkg::WORD_W-1:0] dividend,
  input  logic [pfe_pkg::WORD_W-1:0] divisor,
  output logic                  done,
  output logic [pfe_pkg::WORD_W-1:0] quotient
);
  import pfe_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] q_r, q_nxt;
  logic [WORD_W-1:0] d_r, d_nxt;
  logic [WORD_W:0]   trial;

  // trial subtraction of the shifted remainder
  assign trial = {rem_r, q_r[WORD_W-1]} - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      d_nxt    = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
    end else if (busy_r) begin
      if (!trial[WORD_W]) begin
        rem_nxt = trial[WORD_W-1:0];
        q_nxt   = {q_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[WORD_W-2:0], q_r[WORD_W-1]};
        q_nxt   = {q_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (WORD_W'(0) - q_r) : q_r;

endmodule

[hdl/pfe_datapath.sv]
// ---------------------------------------------------------------------------
// pfe_datapath
// Input capture, number accumulator, operand stack, arithmetic, error
// tracking and output register.
// ---------------------------------------------------------------------------
module pfe_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfe_pkg::pfe_cmd_t            cmd,
  output pfe_pkg::pfe_stat_t           stat,
  input  logic [pfe_pkg::CHAR_W-1:0]   in_char_code,
  input  logic                         in_end_of_expression,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pfe_pkg::WORD_W-1:0]   out_value,
  output logic [pfe_pkg::STATUS_W-1:0] out_status
);
  import pfe_pkg::*;

  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE  = DEPTH_W'(1);
  localparam logic [DEPTH_W-1:0] DEPTH_TWO  = DEPTH_W'(2);

  logic [CHAR_W-1:0]   char_r;
  logic                last_r;
  logic [WORD_W-1:0]   acc_r, acc_nxt;
  logic                pending_r, pending_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [WORD_W-1:0]   x_r, y_r, res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   value_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] fin_status;

  logic                push_en;
  logic [WORD_W-1:0]   push_data;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DEPTH_W-1:0]  depth_rd;
  logic [WORD_W-1:0]   ram_rdata;
  logic [CHAR_W-1:0]   digit;
  logic                div_done;
  logic [WORD_W-1:0]   div_q;

  // character classification
  assign digit = char_r - CHAR_ZERO;
  assign stat.is_digit  = (char_r >= CHAR_ZERO) && (char_r <= CHAR_NINE);
  assign stat.is_space  = (char_r == CHAR_SPACE);
  assign stat.is_arith  = (char_r == CHAR_PLUS) || (char_r == CHAR_MINUS) ||
                          (char_r == CHAR_STAR);
  assign stat.is_div    = (char_r == CHAR_SLASH);
  assign stat.last      = last_r;
  assign stat.pending   = pending_r;
  assign stat.depth_lt2 = (depth_r < DEPTH_TWO);
  assign stat.x_zero    = (x_r == '0);
  assign stat.div_done  = div_done;
  assign stat.out_busy  = out_valid_r && !out_ready;

  // stack read address
  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:  depth_rd = depth_r - DEPTH_W'(1);
      RD_NEXT: depth_rd = depth_r - DEPTH_W'(2);
      default: depth_rd = '0;
    endcase
  end
  assign ram_raddr = depth_rd[ADDR_W-1:0];

  // push onto the stack, overflow drops the word
  assign push_en   = cmd.push_num || cmd.push_res;
  assign push_data = cmd.push_num ? acc_r : res_r;
  assign ram_we    = push_en && (depth_r != DEPTH_FULL);

  pfe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth_r[ADDR_W-1:0]),
    .wdata (push_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfe_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (y_r),
    .divisor  (x_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // final status of the expression
  always_comb begin
    if (err_r != ST_OK) begin
      fin_status = err_r;
    end else if (depth_r != DEPTH_ONE) begin
      fin_status = ST_DEPTH;
    end else begin
      fin_status = ST_OK;
    end
  end

  // expression state update
  always_comb begin
    acc_nxt     = acc_r;
    pending_nxt = pending_r;
    depth_nxt   = depth_r;
    err_nxt     = err_r;
    if (cmd.clear) begin
      acc_nxt     = '0;
      pending_nxt = 1'b0;
      depth_nxt   = '0;
      err_nxt     = ST_OK;
    end else begin
      if (cmd.acc_step) begin
        acc_nxt     = (acc_r << 3) + (acc_r << 1) + WORD_W'(digit[3:0]);
        pending_nxt = 1'b1;
      end
      if (cmd.push_num) begin
        acc_nxt     = '0;
        pending_nxt = 1'b0;
      end
      if (push_en) begin
        if (depth_r == DEPTH_FULL) begin
          if (err_r == ST_OK) begin
            err_nxt = ST_OVER;
          end
        end else begin
          depth_nxt = depth_r + DEPTH_W'(1);
        end
      end
      if (cmd.latch_y) begin
        depth_nxt = depth_r - DEPTH_W'(2);
      end
      if (cmd.flag_few && (err_r == ST_OK)) begin
        err_nxt = ST_FEW;
      end
      if (cmd.flag_div0 && (err_r == ST_OK)) begin
        err_nxt = ST_DIV0;
      end
    end
  end

  // arithmetic result
  always_comb begin
    res_nxt = res_r;
    if (cmd.exec) begin
      case (char_r)
        CHAR_PLUS:  res_nxt = x_r + y_r;
        CHAR_MINUS: res_nxt = y_r - x_r;
        default:    res_nxt = x_r * y_r;
      endcase
    end else if (cmd.div_latch) begin
      res_nxt = div_q;
    end
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pending_r   <= 1'b0;
      depth_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pending_r   <= pending_nxt;
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      char_r <= in_char_code;
      last_r <= in_end_of_expression;
    end
    if (cmd.latch_x) begin
      x_r <= ram_rdata;
    end
    if (cmd.latch_y) begin
      y_r <= ram_rdata;
    end
    res_r <= res_nxt;
    if (cmd.load_out) begin
      status_r <= fin_status;
      value_r  <= (fin_status == ST_OK) ? ram_rdata : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = value_r;
  assign out_status = status_r;

endmodule

[hdl/pfe_ctrl.sv]
// ---------------------------------------------------------------------------
// pfe_ctrl
// Sequencer for one expression character: decode, number flush, operand
// reads, arithmetic, push and end-of-expression result.
// ---------------------------------------------------------------------------
module pfe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfe_pkg::pfe_stat_t  stat,
  output pfe_pkg::pfe_cmd_t   cmd
);
  import pfe_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_OP      = 4'd2;
  localparam logic [3:0] S_RDX     = 4'd3;
  localparam logic [3:0] S_RDY     = 4'd4;
  localparam logic [3:0] S_EXEC    = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_PUSHRES = 4'd7;
  localparam logic [3:0] S_CHKEND  = 4'd8;
  localparam logic [3:0] S_FINRD   = 4'd9;
  localparam logic [3:0] S_FINAL   = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_BASE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_digit) begin
          cmd.acc_step = 1'b1;
          state_nxt    = stat.last ? S_CHKEND : S_IDLE;
        end else begin
          cmd.push_num = stat.pending;
          state_nxt    = S_OP;
        end
      end
      S_OP: begin
        cmd.rd_sel = RD_TOP;
        if (stat.is_space) begin
          state_nxt = S_CHKEND;
        end else if (stat.depth_lt2) begin
          cmd.flag_few = 1'b1;
          state_nxt    = S_CHKEND;
        end else begin
          state_nxt = S_RDX;
        end
      end
      S_RDX: begin
        cmd.latch_x = 1'b1;
        cmd.rd_sel  = RD_NEXT;
        state_nxt   = S_RDY;
      end
      S_RDY: begin
        cmd.latch_y = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_arith) begin
          cmd.exec  = 1'b1;
          state_nxt = S_PUSHRES;
        end else if (stat.is_div && stat.x_zero) begin
          cmd.flag_div0 = 1'b1;
          state_nxt     = S_CHKEND;
        end else if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_CHKEND;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_latch = 1'b1;
          state_nxt     = S_PUSHRES;
        end
      end
      S_PUSHRES: begin
        cmd.push_res = 1'b1;
        state_nxt    = S_CHKEND;
      end
      S_CHKEND: begin
        if (!stat.last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.push_num = stat.pending;
          state_nxt    = S_FINRD;
        end
      end
      S_FINRD: begin
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/postfix_expression_evaluator.sv]
// ---------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression fed one character per transfer and returns
// the final value or an error status on the last character.
//
//   channel  direction  ports                                   transfer
//   in       input      in_char_code, in_end_of_expression      in_valid & in_ready
//   out      output     out_value, out_status                   out_valid & out_ready
//
// A divide waits on the 32-step divider. The last character adds a final
// stack read and waits while the previous result is still held in the
// output register.
// Synchronous active-low reset empties the stack and output register.
// A stalled output only stops the block at the end of the next expression.
// ---------------------------------------------------------------------------
module postfix_expression_evaluator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pfe_pkg::CHAR_W-1:0]          in_char_code,
  input  logic                                in_end_of_expression,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pfe_pkg::WORD_W-1:0]   out_value,
  output logic [pfe_pkg::STATUS_W-1:0]        out_status
);
  import pfe_pkg::*;

  pfe_cmd_t          cmd;
  pfe_stat_t         stat;
  logic [WORD_W-1:0] value;

  // sequencer
  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack, arithmetic and output register
  pfe_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_char_code         (in_char_code),
    .in_end_of_expression (in_end_of_expression),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_value            (value),
    .out_status           (out_status)
  );

  assign out_value = $signed(value);

endmodule

[tb/tb_postfix_expression_evaluator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Feeds postfix expressions one character per transfer: a short directed
// set, then random expressions (mostly well formed, some deep enough to
// overflow the stack, some broken, some plain noise). A scoreboard tracks
// the operand stack and predicts the value and status of every expression.
// ---------------------------------------------------------------------------
module tb_postfix_expression_evaluator;
  import pfe_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RST_CYCLES  = 4;
  localparam int RAND_ITEMS  = 1200;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN       = 100;
  localparam int LIMIT       = 400000;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } expr_result_t;

  // tracks the evaluator state and holds the results still to arrive
  class expr_scoreboard;
    logic [WORD_W-1:0]   stk [STACK_DEPTH];
    int                  depth;
    logic [WORD_W-1:0]   acc;
    bit                  pending;
    logic [STATUS_W-1:0] err;
    expr_result_t        results_q [$];
    int unsigned         errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      foreach (stk[i]) stk[i] = '0;
      depth   = 0;
      acc     = '0;
      pending = 1'b0;
      err     = ST_OK;
    endfunction

    // first error of an expression wins
    function void flag(logic [STATUS_W-1:0] code);
      if (err == ST_OK) err = code;
    endfunction

    function void push_word(logic [WORD_W-1:0] v);
      if (depth >= STACK_DEPTH) begin
        flag(ST_OVER);
      end else begin
        stk[depth] = v;
        depth++;
      end
    endfunction

    function void flush_number();
      if (pending) begin
        push_word(acc);
        acc     = '0;
        pending = 1'b0;
      end
    endfunction

    // signed quotient truncated toward zero, wrapping on most negative / -1
    function logic [WORD_W-1:0] quot_trunc(logic [WORD_W-1:0] y, logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] ay, ax, q;
      ay = y[WORD_W-1] ? -y : y;
      ax = x[WORD_W-1] ? -x : x;
      q  = ay / ax;
      return (y[WORD_W-1] ^ x[WORD_W-1]) ? -q : q;
    endfunction

    // one accepted input transfer
    function void note_input(logic [CHAR_W-1:0] c, logic last);
      logic [WORD_W-1:0]   x, y, val;
      logic [STATUS_W-1:0] st;
      expr_result_t        res;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        acc     = acc * RADIX + {{(WORD_W-4){1'b0}}, c[3:0]};
        pending = 1'b1;
      end else begin
        flush_number();
        if (c != CHAR_SPACE) begin
          if (depth < 2) begin
            flag(ST_FEW);
          end else begin
            x = stk[depth-1];
            y = stk[depth-2];
            depth -= 2;
            case (c)
              CHAR_PLUS:  push_word(x + y);
              CHAR_MINUS: push_word(y - x);
              CHAR_STAR:  push_word(x * y);
              CHAR_SLASH: begin
                if (x == '0) flag(ST_DIV0);
                else push_word(quot_trunc(y, x));
              end
              default: ;
            endcase
          end
        end
      end
      // end of expression: form the result and start afresh
      if (last) begin
        flush_number();
        st  = err;
        val = '0;
        if (st == ST_OK) begin
          if (depth != 1) st = ST_DEPTH;
          else val = stk[0];
        end
        res.value  = val;
        res.status = st;
        results_q.insert(results_q.size(), res);
        clear_state();
      end
    endfunction

    // one accepted result transfer
    function void check_result(logic [WORD_W-1:0] value, logic [STATUS_W-1:0] status);
      expr_result_t e;
      if (results_q.size() == 0) begin
        $error("unexpected result transfer: value %0d status %0d", $signed(value), status);
        errors++;
        return;
      end
      e = results_q.pop_front();
      if (value !== e.value) begin
        $error("value mismatch: expected %0d actual %0d", $signed(e.value), $signed(value));
        errors++;
      end
      if (status !== e.status) begin
        $error("status mismatch: expected %0d actual %0d", e.status, status);
        errors++;
      end
    endfunction

    function int waiting();
      return results_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [CHAR_W-1:0]          in_char_code;
  logic                       in_end_of_expression;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [WORD_W-1:0]   out_value;
  logic [STATUS_W-1:0]        out_status;

  expr_scoreboard sb = new();
  char_item_t     stim_q [$];
  bit             last_num;
  bit             quiet;
  bit             hold_off;
  int             sent_cnt;
  int             cycle_cnt = 0;

  postfix_expression_evaluator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_char_code         (in_char_code),
    .in_end_of_expression (in_end_of_expression),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_value            (out_value),
    .out_status           (out_status)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_char_code, in_end_of_expression);
      if (out_valid && out_ready) sb.check_result(out_value, out_status);
    end
  end

  // stimulus building
  task automatic put_char(input logic [CHAR_W-1:0] code);
    char_item_t it;
    it.code = code;
    it.last = 1'b0;
    stim_q.insert(stim_q.size(), it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic mark_last();
    stim_q[stim_q.size()-1].last = 1'b1;
  endtask

  task automatic put_number();
    int form;
    int n;
    if (last_num) put_char(CHAR_SPACE);
    form = $urandom_range(0, 15);
    if (form < 2) begin
      put_char(CHAR_ZERO);
    end else if (form == 2) begin
      // long run, accumulator may wrap
      n = $urandom_range(9, 12);
      repeat (n) put_char(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
    end else if (form == 3) begin
      case ($urandom_range(0, 2))
        0:       put_text("2147483648");
        1:       put_text("4294967295");
        default: put_text("2147483647");
      endcase
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) put_char(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
    end
    last_num = 1'b1;
  endtask

  task automatic put_operator(input bit any_char);
    if ($urandom_range(0, 3) == 0) put_char(CHAR_SPACE);
    if (any_char && $urandom_range(0, 3) == 0) begin
      put_char(CHAR_W'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0:       put_char(CHAR_PLUS);
        1:       put_char(CHAR_MINUS);
        2:       put_char(CHAR_STAR);
        default: put_char(CHAR_SLASH);
      endcase
    end
    last_num = 1'b0;
  endtask

  // one random expression: well formed, deep, broken or noise
  task automatic gen_expression();
    int  kind;
    int  pushes;
    int  ops;
    int  depth;
    int  start;
    bit  push_first;
    start      = stim_q.size();
    last_num   = 1'b0;
    push_first = 1'b0;
    kind       = $urandom_range(0, 19);
    if (kind == 12) begin
      // most negative over minus one
      put_text("2147483648 4294967295/");
      mark_last();
      return;
    end
    if (kind >= 18) begin
      repeat ($urandom_range(1, 6)) put_char(CHAR_W'($urandom_range(0, 255)));
      mark_last();
      return;
    end
    if (kind < 12) begin
      pushes = $urandom_range(1, 6);
      ops    = pushes - 1;
    end else if (kind < 15) begin
      pushes     = $urandom_range(13, 18);
      ops        = pushes - 1 - $urandom_range(0, 1);
      push_first = 1'b1;
    end else begin
      pushes = $urandom_range(0, 4);
      ops    = $urandom_range(0, 4);
    end
    depth = 0;
    while (pushes > 0 || ops > 0) begin
      if (pushes > 0 && (push_first || depth < 2 || ops == 0 || $urandom_range(0, 1))) begin
        put_number();
        pushes--;
        depth++;
      end else begin
        put_operator(kind >= 15);
        ops--;
        if (depth >= 2) depth--;
      end
    end
    if (stim_q.size() == start || $urandom_range(0, 7) == 0) put_char(CHAR_SPACE);
    mark_last();
  endtask

  task automatic build_directed();
    put_text("3 4+");   mark_last();
    put_text("9 12-");  mark_last();
    put_text("7 6*");   mark_last();
    put_text("0 7-2/"); mark_last();
    put_text("5 0/");   mark_last();
    put_char(CHAR_PLUS); mark_last();
    put_text("1 2");    mark_last();
    put_char(8'h00);    mark_last();
    put_text("4 5");
    put_char(8'hFF);    mark_last();
  endtask

  // drive one item from a falling edge, return at the falling edge after transfer
  task automatic send_item(input char_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_char_code         <= it.code;
    in_end_of_expression <= it.last;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    @(negedge clk);
  endtask

  // result side ready with random bursts of back-pressure
  initial begin : result_sink
    int idle_cnt;
    idle_cnt  = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (idle_cnt > 0) begin
        out_ready <= 1'b0;
        idle_cnt--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        idle_cnt  = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin : long_hold
    hold_off = 1'b0;
    wait (sent_cnt >= HOLD_AT);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // reset, stimulus and end of run
  initial begin : stimulus
    int quiet_from;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_char_code         = '0;
    in_end_of_expression = 1'b0;
    quiet                = 1'b0;
    sent_cnt             = 0;
    build_directed();
    quiet_from = stim_q.size() + RAND_ITEMS * 85 / 100;
    while (stim_q.size() < RAND_ITEMS + 31) gen_expression();
    repeat (RST_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    foreach (stim_q[i]) begin
      quiet = (i >= quiet_from);
      send_item(stim_q[i]);
    end
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
